// ----- rtl/core/brtm_pkg.sv -----
// ----------------------------------------------------------------------------
// brtm_pkg
// Types, constants and codes shared by the best-route table merge block.
// ----------------------------------------------------------------------------
`default_nettype none

package brtm_pkg;

   localparam int TABLE_DEPTH = 256;
   localparam int IDX_W       = $clog2(TABLE_DEPTH);
   localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
   localparam int KEY_W       = 64;
   localparam int SLOT_W      = 8;
   localparam int COUNT_W     = 9;

   localparam logic CMD_OFFER = 1'b0;
   localparam logic CMD_CLEAR = 1'b1;

   typedef enum logic [2:0] {
      ACT_INSERTED = 3'd0,
      ACT_REPLACED = 3'd1,
      ACT_KEPT     = 3'd2,
      ACT_DROPPED  = 3'd3,
      ACT_CLEARED  = 3'd4
   } action_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_COMPARE,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic        cmd;
      logic [63:0] prefix_key;
      logic [31:0] preference;
      logic [7:0]  origin_type;
      logic [7:0]  path_length;
      logic [31:0] route_metric;
      logic [31:0] domain_id;
      logic [31:0] learn_time;
      logic [31:0] speaker_id;
   } req_item_type;

   typedef struct packed {
      action_type  action;
      logic [7:0]  slot;
      logic [8:0]  entry_count;
   } rsp_item_type;

   // route attributes as held in the attribute memory
   typedef struct packed {
      logic [31:0] preference;
      logic [7:0]  origin_type;
      logic [7:0]  path_length;
      logic [31:0] route_metric;
      logic [31:0] domain_id;
      logic [31:0] learn_time;
      logic [31:0] speaker_id;
   } route_attr_type;

   localparam int ATTR_W = $bits(route_attr_type);

endpackage

`default_nettype wire

// ----- rtl/core/brtm_ram.sv -----
// ----------------------------------------------------------------------------
// brtm_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module brtm_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

// ----- rtl/core/brtm_select.sv -----
// ----------------------------------------------------------------------------
// brtm_select
// Route selection: decides whether an offered route beats the stored one.
// ----------------------------------------------------------------------------
`default_nettype none

module brtm_select
   import brtm_pkg::*;
(
   input  wire route_attr_type offer,
   input  wire route_attr_type stored,
   input  wire logic [31:0]    local_domain_id,
   output logic                offer_wins
);

   logic old_local;
   logic new_local;

   assign old_local = (stored.domain_id == local_domain_id);
   assign new_local = (offer.domain_id == local_domain_id);

   // first differing rule decides; full tie keeps the stored route
   always_comb begin
      if (stored.preference != offer.preference) begin
         offer_wins = stored.preference < offer.preference;
      end else if (stored.origin_type != offer.origin_type) begin
         offer_wins = stored.origin_type < offer.origin_type;
      end else if (stored.path_length != offer.path_length) begin
         offer_wins = stored.path_length < offer.path_length;
      end else if (stored.route_metric != offer.route_metric) begin
         offer_wins = stored.route_metric < offer.route_metric;
      end else if (old_local != new_local) begin
         offer_wins = new_local;
      end else if (stored.learn_time != offer.learn_time) begin
         offer_wins = stored.learn_time > offer.learn_time;
      end else if (stored.speaker_id != offer.speaker_id) begin
         offer_wins = stored.speaker_id < offer.speaker_id;
      end else begin
         offer_wins = 1'b0;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/core/best_route_table_merge_top.sv -----
// ----------------------------------------------------------------------------
// best_route_table_merge_top
// Best-route table keyed by a 64-bit prefix key, merged by route preference.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one item: an offer (cmd 0) or a table clear (cmd 1).
//   rsp_* returns one item per request: action, slot and entry count.
//   csr_wr_en/csr_wr_data set local_domain_id; write only while idle.
// Operation:
//   One item at a time. An offer scans the key memory from slot 0 at one
//   key per cycle through its read port. A hit reads the stored route and
//   compares it with the offer, a miss inserts at the fill count or drops
//   when the table is full, and a clear goes straight to the result. The
//   next item is taken in the cycle after the result moves to the output
//   register.
// Reset:
//   Fill count and local_domain_id go to zero; memory contents are left
//   as they are, only slots below the fill count are ever read.
// Stall:
//   A stalled result holds in the output register; one further item may
//   run, then its result waits inside until the output frees up.
// ----------------------------------------------------------------------------
`default_nettype none

module best_route_table_merge_top
   import brtm_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output logic              req_stall,
   input  wire req_item_type req_item,
   output logic              rsp_valid,
   input  wire logic         rsp_stall,
   output rsp_item_type      rsp_item,
   input  wire logic         csr_wr_en,
   input  wire logic [31:0]  csr_wr_data
);

   state_type      state_ff, state_in;
   req_item_type   item_ff, item_in;
   logic [CNT_W-1:0] fill_ff, fill_in;
   logic [CNT_W-1:0] idx_ff, idx_in;
   logic           rd_vld_ff, rd_vld_in;
   logic [IDX_W-1:0] rd_idx_ff, rd_idx_in;
   logic [IDX_W-1:0] slot_ff, slot_in;
   rsp_item_type   res_ff, res_in;
   rsp_item_type   rsp_ff, rsp_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic [31:0]    local_dom_ff, local_dom_in;

   logic           issue;
   logic           key_hit;
   logic           scan_end;
   logic           table_full;
   logic           out_free;
   logic           offer_wins;

   logic           key_rd_en, attr_rd_en;
   logic [IDX_W-1:0] key_rd_addr, attr_rd_addr;
   logic           key_wr_en, attr_wr_en;
   logic [IDX_W-1:0] wr_addr;
   logic [KEY_W-1:0] key_rd_data;
   logic [ATTR_W-1:0] attr_rd_data;
   route_attr_type offer_attr;
   route_attr_type stored_attr;

   assign offer_attr.preference   = item_ff.preference;
   assign offer_attr.origin_type  = item_ff.origin_type;
   assign offer_attr.path_length  = item_ff.path_length;
   assign offer_attr.route_metric = item_ff.route_metric;
   assign offer_attr.domain_id    = item_ff.domain_id;
   assign offer_attr.learn_time   = item_ff.learn_time;
   assign offer_attr.speaker_id   = item_ff.speaker_id;
   assign stored_attr = route_attr_type'(attr_rd_data);

   assign issue      = (idx_ff < fill_ff);
   assign key_hit    = rd_vld_ff && (key_rd_data == item_ff.prefix_key);
   // no read left to issue and the one in flight (if any) missed
   assign scan_end   = !issue && !key_hit;
   assign table_full = (fill_ff == CNT_W'(TABLE_DEPTH));
   assign out_free   = !rsp_valid_ff || !rsp_stall;

   brtm_ram #(
      .WIDTH (KEY_W),
      .DEPTH (TABLE_DEPTH)
   ) u_key_ram (
      .clock   (clock),
      .wr_en   (key_wr_en),
      .wr_addr (wr_addr),
      .wr_data (item_ff.prefix_key),
      .rd_en   (key_rd_en),
      .rd_addr (key_rd_addr),
      .rd_data (key_rd_data)
   );

   brtm_ram #(
      .WIDTH (ATTR_W),
      .DEPTH (TABLE_DEPTH)
   ) u_attr_ram (
      .clock   (clock),
      .wr_en   (attr_wr_en),
      .wr_addr (wr_addr),
      .wr_data (offer_attr),
      .rd_en   (attr_rd_en),
      .rd_addr (attr_rd_addr),
      .rd_data (attr_rd_data)
   );

   brtm_select u_select (
      .offer           (offer_attr),
      .stored          (stored_attr),
      .local_domain_id (local_dom_ff),
      .offer_wins      (offer_wins)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = (req_item.cmd == CMD_CLEAR) ? ST_DONE : ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (key_hit) begin
               state_in = ST_COMPARE;
            end else if (scan_end) begin
               state_in = ST_DONE;
            end
         end
         ST_COMPARE: begin
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // datapath and memory control
   always_comb begin
      item_in      = item_ff;
      fill_in      = fill_ff;
      idx_in       = idx_ff;
      rd_vld_in    = 1'b0;
      rd_idx_in    = rd_idx_ff;
      slot_in      = slot_ff;
      res_in       = res_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      key_rd_en    = 1'b0;
      key_rd_addr  = idx_ff[IDX_W-1:0];
      attr_rd_en   = 1'b0;
      attr_rd_addr = rd_idx_ff;
      key_wr_en    = 1'b0;
      attr_wr_en   = 1'b0;
      wr_addr      = fill_ff[IDX_W-1:0];
      req_stall    = (state_ff != ST_IDLE);
      local_dom_in = csr_wr_en ? csr_wr_data : local_dom_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               item_in = req_item;
               idx_in  = '0;
               if (req_item.cmd == CMD_CLEAR) begin
                  fill_in            = '0;
                  res_in.action      = ACT_CLEARED;
                  res_in.slot        = '0;
                  res_in.entry_count = '0;
               end
            end
         end
         ST_SCAN: begin
            key_rd_en = issue;
            rd_vld_in = issue;
            rd_idx_in = idx_ff[IDX_W-1:0];
            idx_in    = idx_ff + {{(CNT_W-1){1'b0}}, issue};
            if (key_hit) begin
               slot_in    = rd_idx_ff;
               attr_rd_en = 1'b1;
            end else if (scan_end) begin
               if (table_full) begin
                  res_in.action      = ACT_DROPPED;
                  res_in.slot        = '0;
                  res_in.entry_count = COUNT_W'(fill_ff);
               end else begin
                  key_wr_en          = 1'b1;
                  attr_wr_en         = 1'b1;
                  fill_in            = fill_ff + CNT_W'(1);
                  res_in.action      = ACT_INSERTED;
                  res_in.slot        = SLOT_W'(fill_ff);
                  res_in.entry_count = COUNT_W'(fill_ff + CNT_W'(1));
               end
            end
         end
         ST_COMPARE: begin
            wr_addr            = slot_ff;
            attr_wr_en         = offer_wins;
            res_in.action      = offer_wins ? ACT_REPLACED : ACT_KEPT;
            res_in.slot        = SLOT_W'(slot_ff);
            res_in.entry_count = COUNT_W'(fill_ff);
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_in       = res_ff;
               rsp_valid_in = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         fill_ff      <= '0;
         rd_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
         local_dom_ff <= '0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         rd_vld_ff    <= rd_vld_in;
         rsp_valid_ff <= rsp_valid_in;
         local_dom_ff <= local_dom_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff   <= item_in;
      idx_ff    <= idx_in;
      rd_idx_ff <= rd_idx_in;
      slot_ff   <= slot_in;
      res_ff    <= res_in;
      rsp_ff    <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

endmodule

`default_nettype wire

// ----- dv/best_route_table_merge_checker.sv -----
// ----------------------------------------------------------------------------
// best_route_table_merge_checker
// Watches the request, result and register ports of the best-route table.
// It keeps its own copy of the route table and the local domain id, predicts
// the result of every accepted item and compares each returned result field
// by field against the oldest prediction.
// ----------------------------------------------------------------------------
module best_route_table_merge_checker
   import brtm_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   input  wire logic         req_stall,
   input  wire req_item_type req_item,
   input  wire logic         rsp_valid,
   input  wire logic         rsp_stall,
   input  wire rsp_item_type rsp_item,
   input  wire logic         csr_wr_en,
   input  wire logic [31:0]  csr_wr_data,
   output int                error_total,
   output int                results_owed
);
   timeunit 1ns;
   timeprecision 1ps;

   logic [63:0]    table_key [TABLE_DEPTH];
   route_attr_type table_route [TABLE_DEPTH];
   int             routes_held;
   logic [31:0]    local_domain;
   rsp_item_type   owed_results [$];
   rsp_item_type   want;

   // true when the offered route displaces the held one
   function automatic bit offer_beats(route_attr_type held, route_attr_type offer);
      bit held_local;
      bit offer_local;
      if (held.preference != offer.preference)
         return offer.preference > held.preference;
      if (held.origin_type != offer.origin_type)
         return offer.origin_type > held.origin_type;
      if (held.path_length != offer.path_length)
         return offer.path_length > held.path_length;
      if (held.route_metric != offer.route_metric)
         return offer.route_metric > held.route_metric;
      held_local  = (held.domain_id == local_domain);
      offer_local = (offer.domain_id == local_domain);
      if (held_local != offer_local)
         return offer_local;
      // older route wins
      if (held.learn_time != offer.learn_time)
         return offer.learn_time < held.learn_time;
      if (held.speaker_id != offer.speaker_id)
         return offer.speaker_id > held.speaker_id;
      return 1'b0;
   endfunction

   function automatic rsp_item_type merge_route(req_item_type it);
      rsp_item_type   res;
      route_attr_type offer;
      int             hit;
      // attributes occupy the low bits of the request in the same order
      offer = route_attr_type'(it[ATTR_W-1:0]);
      hit = -1;
      res.slot = '0;
      if (it.cmd == CMD_CLEAR) begin
         routes_held = 0;
         res.action = ACT_CLEARED;
      end else begin
         for (int i = 0; i < routes_held && hit < 0; i++)
            if (table_key[i] == it.prefix_key)
               hit = i;
         if (hit >= 0) begin
            res.slot = SLOT_W'(hit);
            if (offer_beats(table_route[hit], offer)) begin
               table_route[hit] = offer;
               res.action = ACT_REPLACED;
            end else begin
               res.action = ACT_KEPT;
            end
         end else if (routes_held < TABLE_DEPTH) begin
            res.slot = SLOT_W'(routes_held);
            table_key[routes_held] = it.prefix_key;
            table_route[routes_held] = offer;
            routes_held++;
            res.action = ACT_INSERTED;
         end else begin
            res.action = ACT_DROPPED;
         end
      end
      res.entry_count = COUNT_W'(routes_held);
      return res;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         routes_held = 0;
         local_domain = '0;
         error_total = 0;
         owed_results.delete();
      end else begin
         if (csr_wr_en)
            local_domain = csr_wr_data;
         if (rsp_valid && !rsp_stall) begin
            if (owed_results.size() == 0) begin
               $error("unexpected result item: action %0d slot %0d entry_count %0d",
                      rsp_item.action, rsp_item.slot, rsp_item.entry_count);
               error_total++;
            end else begin
               want = owed_results.pop_front();
               if (rsp_item.action !== want.action) begin
                  $error("action: expected %0d, got %0d", want.action, rsp_item.action);
                  error_total++;
               end
               if (rsp_item.slot !== want.slot) begin
                  $error("slot: expected %0d, got %0d", want.slot, rsp_item.slot);
                  error_total++;
               end
               if (rsp_item.entry_count !== want.entry_count) begin
                  $error("entry_count: expected %0d, got %0d",
                         want.entry_count, rsp_item.entry_count);
                  error_total++;
               end
            end
         end
         if (req_valid && !req_stall)
            owed_results.push_back(merge_route(req_item));
      end
      results_owed = owed_results.size();
   end

endmodule

// ----- dv/tb_best_route_table_merge_top.sv -----
// ----------------------------------------------------------------------------
// tb_best_route_table_merge_top
// Stimulus and verdict for the best-route table merge block. A directed run
// walks each selection rule, all but origin type both ways, plus clears and
// field extremes; random phases hammer a small key pool (deep tie-breaks)
// and fill the table past capacity, each under a new local domain id and an
// idling pattern. Checking lives in the checker beside the block.
// ----------------------------------------------------------------------------
module tb_best_route_table_merge_top;
   import brtm_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int STALL_LIMIT = 4 * (TABLE_DEPTH + 64);

   logic         clock;
   logic         reset;
   logic         req_valid;
   logic         req_stall;
   req_item_type req_item;
   logic         rsp_valid;
   logic         rsp_stall;
   rsp_item_type rsp_item;
   logic         csr_wr_en;
   logic [31:0]  csr_wr_data;

   int           error_total;
   int           results_owed;
   int           idle_mode;     // 0 no gaps, 1 random gaps, 2 half the items gapped
   int           quiet_cycles;
   logic [31:0]  domain_now;

   best_route_table_merge_top DUT (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_item    (req_item),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_item    (rsp_item),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   best_route_table_merge_checker u_checker (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_item     (req_item),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_item     (rsp_item),
      .csr_wr_en    (csr_wr_en),
      .csr_wr_data  (csr_wr_data),
      .error_total  (error_total),
      .results_owed (results_owed)
   );

   always #4 clock = ~clock;

   function automatic int pick_wait();
      if (idle_mode == 0)
         return 0;
      if (idle_mode == 2 && $urandom_range(0, 1) == 0)
         return 0;
      return $urandom_range(0, 15);
   endfunction

   // mostly one value so that comparisons fall through to the later rules
   function automatic logic [31:0] pick_word();
      case ($urandom_range(0, 9))
         0:       return $urandom;
         1:       return $urandom_range(0, 2);
         default: return 32'd1;
      endcase
   endfunction

   function automatic logic [7:0] pick_byte();
      case ($urandom_range(0, 9))
         0:       return 8'($urandom);
         1:       return 8'($urandom_range(0, 2));
         default: return 8'd1;
      endcase
   endfunction

   function automatic logic [31:0] pick_domain();
      case ($urandom_range(0, 9))
         0, 1, 2, 3: return domain_now;
         4, 5, 6:    return domain_now + 32'd1;
         default:    return $urandom;
      endcase
   endfunction

   function automatic req_item_type random_route(logic [63:0] key);
      req_item_type r;
      r.cmd          = CMD_OFFER;
      r.prefix_key   = key;
      r.preference   = pick_word();
      r.origin_type  = pick_byte();
      r.path_length  = pick_byte();
      r.route_metric = pick_word();
      r.domain_id    = pick_domain();
      r.learn_time   = pick_word();
      r.speaker_id   = pick_word();
      return r;
   endfunction

   task automatic send_item(input req_item_type it);
      int gap;
      gap = pick_wait();
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_item <= it;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic send_clear();
      req_item_type r;
      r = random_route({$urandom, $urandom});
      r.cmd = CMD_CLEAR;
      send_item(r);
   endtask

   task automatic wait_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      while (results_owed != 0)
         @(negedge clock);
   endtask

   task automatic set_local_domain(input logic [31:0] value);
      wait_drained();
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      domain_now = value;
   endtask

   task automatic run_directed();
      req_item_type r;
      req_item_type z;
      send_clear();                    // clear on an empty table
      z = '0;
      z.cmd = CMD_OFFER;
      send_item(z);                    // key zero, all attributes zero
      r.cmd          = CMD_OFFER;
      r.prefix_key   = '1;
      r.preference   = 32'd100;
      r.origin_type  = 8'd5;
      r.path_length  = 8'd5;
      r.route_metric = 32'd100;
      r.domain_id    = domain_now;
      r.learn_time   = 32'd100;
      r.speaker_id   = 32'd100;
      send_item(r);
      send_item(r);                    // full tie keeps the stored route
      r.preference = 32'd99;
      send_item(r);
      r.preference = 32'd100;
      r.origin_type = 8'd6;
      send_item(r);
      r.path_length = 8'd4;
      send_item(r);
      r.path_length = 8'd6;
      send_item(r);
      r.route_metric = 32'd99;
      send_item(r);
      r.route_metric = 32'd101;
      send_item(r);
      r.domain_id = domain_now + 32'd7;  // foreign route loses to a local one
      send_item(r);
      r.preference = 32'd101;
      send_item(r);
      r.domain_id = domain_now;          // local route beats a foreign one
      send_item(r);
      r.learn_time = 32'd101;
      send_item(r);
      r.learn_time = 32'd99;
      send_item(r);
      r.speaker_id = 32'd99;
      send_item(r);
      r.speaker_id = 32'd101;
      send_item(r);
      z = '1;
      z.cmd = CMD_OFFER;
      z.prefix_key = '0;
      send_item(z);                    // all-ones attributes on key zero
      send_item(z);
      send_clear();
   endtask

   // few keys, frequent hits, so most offers go through the selection rules
   task automatic run_pool_phase(input int count);
      logic [63:0] pool [12];
      foreach (pool[i])
         pool[i] = {$urandom, $urandom};
      pool[0] = '0;
      pool[1] = '1;
      repeat (count) begin
         if ($urandom_range(0, 29) == 0)
            send_clear();
         else
            send_item(random_route(pool[$urandom_range(0, 11)]));
      end
   endtask

   // mostly new keys: the table fills, then new keys get dropped
   task automatic run_fill_phase(input int count);
      logic [63:0] seen_keys [$];
      logic [63:0] key;
      send_clear();
      repeat (count) begin
         if (seen_keys.size() > 0 && $urandom_range(0, 9) == 0) begin
            key = seen_keys[$urandom_range(0, seen_keys.size() - 1)];
         end else begin
            key = {$urandom, $urandom};
            seen_keys.push_back(key);
         end
         send_item(random_route(key));
      end
      send_clear();                    // clear on a full table
   endtask

   initial begin : rsp_drain
      int hold;
      hold = 0;
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            hold--;
         end else begin
            rsp_stall <= 1'b0;
         end
         @(posedge clock);
         if (rsp_valid && !rsp_stall)
            hold = pick_wait();
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("best_route_table_merge_top verification failed");
            $finish;
         end
      end
   end

   initial begin
      clock = 1'b0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_item = '0;
      csr_wr_en = 1'b0;
      csr_wr_data = '0;
      idle_mode = 1;
      domain_now = '0;
      repeat (6) @(negedge clock);
      reset <= 1'b0;

      set_local_domain(32'h0000_0000);
      run_directed();

      idle_mode = 0;
      set_local_domain(32'hFFFF_FFFF);
      run_pool_phase(220);

      idle_mode = 1;
      set_local_domain($urandom);
      run_fill_phase(330);

      idle_mode = 2;
      set_local_domain($urandom);
      run_pool_phase(220);

      idle_mode = 1;
      set_local_domain(32'h8000_0000);
      run_fill_phase(330);

      idle_mode = 2;
      set_local_domain($urandom);
      run_pool_phase(180);

      wait_drained();
      repeat (TABLE_DEPTH + 8) @(negedge clock);
      if (error_total == 0)
         $display("best_route_table_merge_top verification clean");
      else
         $display("best_route_table_merge_top verification failed");
      $finish;
   end

endmodule
